/* rtl/hbad_pkg.sv */
// hbad_pkg: shared types, address map constants and codes for the bus address decoder
// no dependencies; imported by every module of the decoder
`default_nettype none

package hbad_pkg;

    // field widths
    localparam int ADDR_W   = 24;
    localparam int OFFS_W   = 22;
    localparam int LEN_W    = 23;
    localparam int DATA_W   = 8;
    localparam int TIMERS   = 4;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    // address map
    localparam logic [ADDR_W-1:0] RAM_LAST      = 24'h00BFFF;
    localparam logic [3:0]        MB_LOW        = 4'h0;
    localparam logic [3:0]        MB_LOROM_A    = 4'h2;
    localparam logic [3:0]        MB_LOROM_B    = 4'h3;
    localparam logic [3:0]        MB_HIROM_A    = 4'h8;
    localparam logic [3:0]        MB_HIROM_B    = 4'h9;
    localparam logic [3:0]        MB_BIOS       = 4'hF;
    localparam logic [ADDR_W-1:0] FLASH_CMD_A   = 24'h202AAA;
    localparam logic [ADDR_W-1:0] FLASH_CMD_B   = 24'h205555;
    localparam logic [ADDR_W-1:0] STATUS_A      = 24'h220000;
    localparam logic [ADDR_W-1:0] STATUS_B      = 24'h230000;
    localparam logic [ADDR_W-1:0] BLOCK_MASK    = 24'hFFFF00;
    localparam logic [LEN_W-1:0]  LOROM_SIZE    = 23'h200000;

    // i/o addresses
    localparam logic [ADDR_W-1:0] IO_TIMER_RUN  = 24'h000020;
    localparam logic [ADDR_W-1:0] IO_NOISE      = 24'h0000A0;
    localparam logic [ADDR_W-1:0] IO_TONE       = 24'h0000A1;
    localparam logic [ADDR_W-1:0] IO_DAC        = 24'h0000A2;
    localparam logic [ADDR_W-1:0] IO_NMI        = 24'h0000BA;

    // access kinds
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    typedef enum logic [2:0] {
        RG_RAM    = 3'd0,
        RG_BIOS   = 3'd1,
        RG_ROM    = 3'd2,
        RG_STATUS = 3'd3,
        RG_NONE   = 3'd4
    } t_region;

    typedef enum logic [1:0] {
        REG_ROM_PRESENT  = 2'd0,
        REG_ROM_LENGTH   = 2'd1,
        REG_FLASH_UNLOCK = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              sound_direct;
    } t_bus_req;

    typedef struct packed {
        t_region           region;
        logic [OFFS_W-1:0] offset;
        logic              flash_error;
        logic              flash_block_write;
        logic [ADDR_W-1:0] flash_block_addr;
        logic              tone_strobe;
        logic              noise_strobe;
        logic              dac_strobe;
        logic [TIMERS-1:0] timer_clear;
        logic              nmi_strobe;
    } t_bus_rsp;

    typedef struct packed {
        logic             rom_present;
        logic [LEN_W-1:0] rom_length;
        logic             flash_unlock;
    } t_cfg;

    typedef struct packed {
        logic flash_command_pending;
        logic status_read_pending;
        logic flash_error_flag;
    } t_flags;

endpackage

`default_nettype wire

/* rtl/hbad_apb_regs.sv */
// hbad_apb_regs: apb configuration registers (rom present, rom length, flash unlock)
// depends on hbad_pkg
`default_nettype none

module hbad_apb_regs
    import hbad_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready,
    output      t_cfg              o_cfg
);

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    t_reg_index w_index;
    logic       w_write;

    assign pready  = 1'b1;
    assign w_index = t_reg_index'(paddr[APB_AW-1:2]);
    assign w_write = psel && penable && pwrite;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (w_write) begin
            unique case (w_index)
                REG_ROM_PRESENT:  n_cfg.rom_present  = pwdata[0];
                REG_ROM_LENGTH:   n_cfg.rom_length   = pwdata[LEN_W-1:0];
                REG_FLASH_UNLOCK: n_cfg.flash_unlock = pwdata[0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // read back
    always_comb begin
        prdata = '0;
        unique case (w_index)
            REG_ROM_PRESENT:  prdata[0]         = r_cfg.rom_present;
            REG_ROM_LENGTH:   prdata[LEN_W-1:0] = r_cfg.rom_length;
            REG_FLASH_UNLOCK: prdata[0]         = r_cfg.flash_unlock;
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/hbad_decode.sv */
// hbad_decode: address decode of one registered access and the three sticky flags
// depends on hbad_pkg
`default_nettype none

module hbad_decode
    import hbad_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_advance,
    input  wire t_bus_req i_req,
    input  wire t_cfg     i_cfg,
    output      t_bus_rsp o_rsp
);

    t_flags            r_flags;
    t_flags            n_flags;
    t_bus_rsp          w_rsp;
    logic [3:0]        w_mb;
    logic              w_lo_mb;
    logic              w_hi_mb;
    logic              w_lo_fit;
    logic              w_hi_fit;
    logic              w_status_addr;
    logic              w_cmd_addr;
    logic [OFFS_W-1:0] w_lo_off;
    logic [OFFS_W-1:0] w_hi_off;

    // address classification
    assign w_mb          = i_req.address[ADDR_W-1:ADDR_W-4];
    assign w_lo_mb       = (w_mb == MB_LOROM_A) || (w_mb == MB_LOROM_B);
    assign w_hi_mb       = (w_mb == MB_HIROM_A) || (w_mb == MB_HIROM_B);
    assign w_status_addr = (i_req.address == STATUS_A) || (i_req.address == STATUS_B);
    assign w_cmd_addr    = (i_req.address == FLASH_CMD_A) || (i_req.address == FLASH_CMD_B);
    assign w_lo_off      = {1'b0, i_req.address[20:0]};
    assign w_hi_off      = {1'b1, i_req.address[20:0]};

    // length limits: low rom up to base+length, high rom only past 2 MiB
    assign w_lo_fit = {1'b0, w_lo_off} <= i_cfg.rom_length;
    assign w_hi_fit = (i_cfg.rom_length > LOROM_SIZE) && ({1'b0, w_hi_off} <= i_cfg.rom_length);

    // decode and flag update
    always_comb begin
        logic lo;
        logic hi;
        lo      = i_cfg.rom_present && w_lo_mb;
        hi      = i_cfg.rom_present && w_hi_mb;
        n_flags = r_flags;
        w_rsp   = '0;
        w_rsp.region = RG_NONE;
        if (i_req.mode == MODE_READ) begin
            priority if (w_mb == MB_LOW) begin
                if (i_req.address <= RAM_LAST) begin
                    w_rsp.region = RG_RAM;
                    w_rsp.offset = i_req.address[OFFS_W-1:0];
                end
            end else if (w_mb == MB_BIOS) begin
                w_rsp.region = RG_BIOS;
                w_rsp.offset = {6'b0, i_req.address[15:0]};
            end else if (w_lo_mb) begin
                w_rsp.region = RG_ROM;
                w_rsp.offset = w_lo_off;
                // pending status read is consumed by the next rom read in megabyte MB_LOROM_A
                if ((w_mb == MB_LOROM_A) && r_flags.status_read_pending) begin
                    n_flags.status_read_pending = 1'b0;
                    if (w_status_addr) begin
                        w_rsp.region = RG_STATUS;
                        w_rsp.offset = '0;
                    end
                end
            end else if (w_hi_mb) begin
                w_rsp.region = RG_ROM;
                w_rsp.offset = w_hi_off;
            end else if (i_cfg.flash_unlock) begin
                n_flags.flash_error_flag = 1'b1;
            end else begin
                // unmapped read while locked: no target
                w_rsp.region = RG_NONE;
            end
        end else begin
            priority if (i_req.address <= RAM_LAST) begin
                w_rsp.region = RG_RAM;
                w_rsp.offset = i_req.address[OFFS_W-1:0];
            end else if (i_cfg.flash_unlock) begin
                priority if (lo) begin
                    if (w_lo_fit) begin
                        w_rsp.region = RG_ROM;
                        w_rsp.offset = w_lo_off;
                    end
                end else if (hi) begin
                    if (w_hi_fit) begin
                        w_rsp.region = RG_ROM;
                        w_rsp.offset = w_hi_off;
                    end
                end else begin
                    n_flags.flash_error_flag = 1'b1;
                end
            end else if (lo) begin
                priority if (w_cmd_addr) begin
                    n_flags.flash_command_pending = 1'b1;
                end else if (w_status_addr) begin
                    n_flags.status_read_pending = 1'b1;
                end else if (r_flags.flash_command_pending) begin
                    // locked rom write after a command: block write-back
                    w_rsp.flash_block_write       = 1'b1;
                    w_rsp.flash_block_addr        = i_req.address & BLOCK_MASK;
                    n_flags.flash_command_pending = 1'b0;
                    if (w_lo_fit) begin
                        w_rsp.region = RG_ROM;
                        w_rsp.offset = w_lo_off;
                    end
                end else begin
                    // plain locked rom write: ignored
                    w_rsp.region = RG_NONE;
                end
            end else begin
                // locked write outside ram and low rom: no target
                w_rsp.region = RG_NONE;
            end
            // i/o strobes
            w_rsp.tone_strobe  = i_req.sound_direct && (i_req.address == IO_TONE);
            w_rsp.noise_strobe = i_req.sound_direct && (i_req.address == IO_NOISE);
            w_rsp.dac_strobe   = (i_req.address == IO_DAC);
            w_rsp.nmi_strobe   = (i_req.address == IO_NMI);
            if (i_req.address == IO_TIMER_RUN) begin
                w_rsp.timer_clear = ~i_req.write_data[TIMERS-1:0];
            end
        end
        w_rsp.flash_error = n_flags.flash_error_flag;
    end

    // flags move only when the transaction goes on to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
        end else if (i_advance) begin
            r_flags <= n_flags;
        end
    end

    assign o_rsp = w_rsp;

endmodule

`default_nettype wire

/* rtl/handheld_bus_address_decoder_top.sv */
// handheld_bus_address_decoder_top: input register, decode stage and result register
// depends on hbad_pkg, hbad_apb_regs, hbad_decode
//
//   channel | direction | handshake               | payload
//   in      | input     | i_in_valid / o_in_ready | i_in_data  (t_bus_req)
//   out     | output    | o_out_valid/ i_out_ready| o_out_data (t_bus_rsp)
//   cfg     | input     | psel, penable, pready   | paddr, pwdata, prdata
//
// one transaction per cycle sustained while i_out_ready is high; results pass the
// input register and the result register; the decode between them sets the cycle time
// synchronous active-low reset clears valids, flags and configuration
// a stalled result holds; the input register keeps taking a transaction whenever
// the result register is free or being emptied in the same cycle
`default_nettype none

module handheld_bus_address_decoder_top
    import hbad_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output      logic              o_in_ready,
    input  wire t_bus_req          i_in_data,
    output      logic              o_out_valid,
    input  wire logic              i_out_ready,
    output      t_bus_rsp          o_out_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output      logic [APB_DW-1:0] prdata,
    output      logic              pready
);

    logic     r_req_valid;
    t_bus_req r_req;
    logic     r_rsp_valid;
    t_bus_rsp r_rsp;
    logic     w_advance;
    t_cfg     w_cfg;
    t_bus_rsp w_rsp;

    hbad_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    hbad_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_req     (r_req),
        .i_cfg     (w_cfg),
        .o_rsp     (w_rsp)
    );

    // pipeline flow control
    assign w_advance  = r_req_valid && (!r_rsp_valid || i_out_ready);
    assign o_in_ready = !r_req_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_req_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req <= i_in_data;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_advance) begin
            r_rsp_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_rsp <= w_rsp;
        end
    end

    assign o_out_valid = r_rsp_valid;
    assign o_out_data  = r_rsp;

endmodule

`default_nettype wire

/* rtl/hbad_checker.sv */
// hbad_checker: port-level checks on the decoder results, bound to the top level
// depends on hbad_pkg and handheld_bus_address_decoder_top
`default_nettype none

module hbad_checker
    import hbad_pkg::*;
(
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    input wire logic     o_out_valid,
    input wire logic     i_out_ready,
    input wire t_bus_rsp o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // no offset without a real target
    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.region == RG_NONE || o_out_data.region == RG_STATUS)
        |-> o_out_data.offset == '0)
        else $error("offset set for empty or status target");

    // block address only with a request, always block aligned
    a_block_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.flash_block_write || o_out_data.flash_block_addr == '0)
        && o_out_data.flash_block_addr[7:0] == 8'h00)
        else $error("bad flash block address");

    // i/o strobes come from distinct addresses and never with a block request
    a_strobes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones({o_out_data.tone_strobe, o_out_data.noise_strobe,
        o_out_data.dac_strobe, o_out_data.nmi_strobe, |o_out_data.timer_clear,
        o_out_data.flash_block_write}) <= 1)
        else $error("more than one strobe in one result");

    // the flash error flag is sticky
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.flash_error && i_out_ready ##1 o_out_valid
        |-> o_out_data.flash_error)
        else $error("flash error flag dropped");

endmodule

bind handheld_bus_address_decoder_top hbad_checker u_hbad_checker (.*);

`default_nettype wire
